>>> design/cwt_pkg.sv
// Shared types and constants for the collision warning block.
`timescale 1ns / 1ps
package cwt_pkg;

    // classified item queue between the front and the back
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = 2;
    localparam int QCNT_BITS = 3;

    // time to collision arithmetic
    localparam int          DIV_BITS  = 20;
    localparam int          CNT_BITS  = 5;
    localparam int          RATE_BITS = 15;
    localparam logic [19:0] TTC_NUM   = 20'd1024000;
    localparam logic [15:0] TTC_INF   = 16'hFFFF;
    localparam logic [15:0] TTC_MAX   = 16'hFFFE;
    localparam logic [14:0] MIN_RATE  = 15'd2;
    localparam logic [7:0]  MAX_CLASS = 8'd6;
    localparam logic [7:0]  HITS_MAX  = 8'hFF;

    // severity codes
    localparam logic [1:0] SEV_SAFE    = 2'd0;
    localparam logic [1:0] SEV_CAUTION = 2'd1;
    localparam logic [1:0] SEV_WARN    = 2'd2;
    localparam logic [1:0] SEV_ALERT   = 2'd3;

    // register indexes
    localparam logic [2:0] REG_LEFT    = 3'd0;
    localparam logic [2:0] REG_RIGHT   = 3'd1;
    localparam logic [2:0] REG_MIN_H   = 3'd2;
    localparam logic [2:0] REG_ALERT   = 3'd3;
    localparam logic [2:0] REG_WARN    = 3'd4;
    localparam logic [2:0] REG_CAUTION = 3'd5;
    localparam logic [2:0] REG_RAISE   = 3'd6;
    localparam logic [2:0] REG_CLEAR   = 3'd7;

    localparam int RIGHT_RESET = 4095;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_FINISH
    } t_back_state;

    typedef struct packed {
        logic [15:0] alert_limit;
        logic [15:0] warn_limit;
        logic [15:0] caution_limit;
        logic [7:0]  raise_count;
        logic [7:0]  clear_count;
    } t_cfg_back;

    typedef struct packed {
        logic closing;
        logic last;
    } t_cls;

    typedef struct packed {
        logic       start;
        logic [14:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [19:0] quot;
    } t_div_sts;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_sts;

endpackage

>>> design/cwt_front.sv
// Front end: accepts items, filters them and classifies closing tracks.
`timescale 1ns / 1ps
module cwt_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_push,
    input  cwt_pkg::t_q_sts       i_q_sts,
    input  logic [COORD_BITS-1:0] i_left,
    input  logic [COORD_BITS-1:0] i_right,
    input  logic [COORD_BITS-1:0] i_min_height,
    input  logic                  i_track_present,
    input  logic [7:0]            i_object_class,
    input  logic [COORD_BITS-1:0] i_centre_x_px,
    input  logic [COORD_BITS-1:0] i_box_height_px,
    input  logic signed [15:0]    i_height_rate,
    input  logic                  i_frame_last,
    output logic                  o_q_push,
    output cwt_pkg::t_cls         o_cls,
    output logic [14:0]           o_rate
);
    import cwt_pkg::*;

    logic keep;
    logic closing;

    always_comb begin
        keep = i_track_present
            && (i_object_class <= MAX_CLASS)
            && (i_centre_x_px >= i_left)
            && (i_centre_x_px <= i_right)
            && (i_box_height_px >= i_min_height);
        closing = !i_height_rate[15] && (i_height_rate[14:0] >= MIN_RATE);
    end

    // a kept track with no closing rate can never become critical: drop it
    assign o_cls.closing = keep && closing;
    assign o_cls.last    = i_frame_last;
    assign o_rate        = i_height_rate[14:0];
    assign o_q_push      = i_push && !i_q_sts.full && ((keep && closing) || i_frame_last);

endmodule

>>> design/cwt_queue.sv
// Short queue of classified items between the front and the back.
`timescale 1ns / 1ps
module cwt_queue #(
    parameter int WIDTH = 53
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output cwt_pkg::t_q_sts  o_sts
);
    import cwt_pkg::*;

    logic [WIDTH-1:0]     r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_BITS-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data      = r_mem[r_rd_ptr];
    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == QCNT_BITS'(QDEPTH));

endmodule

>>> design/cwt_div.sv
// Restoring serial divider: 1024000 / rate, one quotient bit a cycle.
`timescale 1ns / 1ps
module cwt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cwt_pkg::t_div_req i_req,
    output cwt_pkg::t_div_sts o_sts
);
    import cwt_pkg::*;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    logic [14:0]         r_rem, n_rem;
    logic [19:0]         r_quot, n_quot;
    logic [14:0]         r_div, n_div;
    logic [15:0]         trial;
    logic [15:0]         diff;
    logic                ge;

    always_comb begin
        trial  = {r_rem, r_quot[DIV_BITS-1]};
        diff   = trial - {1'b0, r_div};
        ge     = (trial >= {1'b0, r_div});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_div  = r_div;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quot = TTC_NUM;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so 15 bits hold it
            n_rem  = ge ? diff[14:0] : trial[14:0];
            n_quot = {r_quot[DIV_BITS-2:0], ge};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_BITS'(DIV_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_div  <= n_div;
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_sts.quot = r_quot;

endmodule

>>> design/cwt_back.sv
// Back end: frame minimum, severity, hysteresis and the result register.
`timescale 1ns / 1ps
module cwt_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cwt_pkg::t_cfg_back     i_cfg,
    input  cwt_pkg::t_q_sts        i_q_sts,
    input  cwt_pkg::t_cls          i_q_cls,
    input  logic [15:0]            i_q_number,
    input  logic [7:0]             i_q_class,
    input  logic [COORD_BITS-1:0]  i_q_height,
    input  logic [14:0]            i_q_rate,
    output logic                   o_q_pop,
    output cwt_pkg::t_div_req      o_div_req,
    input  cwt_pkg::t_div_sts      i_div_sts,
    input  logic                   i_pop,
    output logic                   o_empty,
    output logic [1:0]             o_warning_state,
    output logic [15:0]            o_best_ttc_ms,
    output logic                   o_critical_valid,
    output logic [15:0]            o_critical_track,
    output logic [7:0]             o_critical_class,
    output logic [COORD_BITS-1:0]  o_critical_height_px
);
    import cwt_pkg::*;

    t_back_state r_state, n_state;

    logic                  r_ent_last;
    logic [15:0]           r_ent_number;
    logic [7:0]            r_ent_class;
    logic [COORD_BITS-1:0] r_ent_height;

    logic                  r_best_valid, n_best_valid;
    logic [15:0]           r_frame_ttc, n_frame_ttc;
    logic [15:0]           r_best_track, n_best_track;
    logic [7:0]            r_best_class, n_best_class;
    logic [COORD_BITS-1:0] r_best_height, n_best_height;

    logic [1:0]            r_shown, n_shown;
    logic [1:0]            r_cand, n_cand;
    logic [7:0]            r_hits, n_hits;

    logic                  r_out_valid, n_out_valid;
    logic [1:0]            r_out_state;
    logic [15:0]           r_out_ttc;
    logic                  r_out_cvalid;
    logic [15:0]           r_out_track;
    logic [7:0]            r_out_class;
    logic [COORD_BITS-1:0] r_out_height;

    logic                  q_pop;
    logic                  do_update;
    logic                  do_finish;
    logic [15:0]           ttc_sat;
    logic [1:0]            observed;
    logic [7:0]            hits_step;
    logic [7:0]            need;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (q_pop) begin
                    if (i_q_cls.closing) begin
                        n_state = BK_DIV;
                    end else if (i_q_cls.last) begin
                        n_state = BK_FINISH;
                    end
                end
            end
            BK_DIV: begin
                if (do_update) begin
                    n_state = r_ent_last ? BK_FINISH : BK_IDLE;
                end
            end
            BK_FINISH: begin
                if (do_finish) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        q_pop     = 1'b0;
        do_update = 1'b0;
        do_finish = 1'b0;
        case (r_state)
            BK_IDLE:   q_pop     = !i_q_sts.empty;
            BK_DIV:    do_update = i_div_sts.done;
            BK_FINISH: do_finish = !r_out_valid || i_pop;
            default:   q_pop     = 1'b0;
        endcase
    end

    assign o_q_pop           = q_pop;
    assign o_div_req.start   = q_pop && i_q_cls.closing;
    assign o_div_req.divisor = i_q_rate;

    // frame minimum: strict compare keeps the earlier track on a tie
    always_comb begin
        ttc_sat       = (i_div_sts.quot > {4'b0, TTC_MAX}) ? TTC_MAX : i_div_sts.quot[15:0];
        n_best_valid  = r_best_valid;
        n_frame_ttc   = r_frame_ttc;
        n_best_track  = r_best_track;
        n_best_class  = r_best_class;
        n_best_height = r_best_height;
        if (do_finish) begin
            n_best_valid  = 1'b0;
            n_frame_ttc   = TTC_INF;
            n_best_track  = '0;
            n_best_class  = '0;
            n_best_height = '0;
        end else if (do_update && (ttc_sat < r_frame_ttc)) begin
            n_best_valid  = 1'b1;
            n_frame_ttc   = ttc_sat;
            n_best_track  = r_ent_number;
            n_best_class  = r_ent_class;
            n_best_height = r_ent_height;
        end
    end

    // severity and hysteresis
    always_comb begin
        if (r_frame_ttc == TTC_INF) begin
            observed = SEV_SAFE;
        end else if (r_frame_ttc <= i_cfg.alert_limit) begin
            observed = SEV_ALERT;
        end else if (r_frame_ttc <= i_cfg.warn_limit) begin
            observed = SEV_WARN;
        end else if (r_frame_ttc <= i_cfg.caution_limit) begin
            observed = SEV_CAUTION;
        end else begin
            observed = SEV_SAFE;
        end

        need      = (observed > r_shown) ? i_cfg.raise_count : i_cfg.clear_count;
        hits_step = (r_hits == HITS_MAX) ? r_hits : r_hits + 1'b1;
        n_shown   = r_shown;
        n_cand    = r_cand;
        n_hits    = r_hits;
        if (do_finish) begin
            if (observed != r_shown) begin
                if (observed != r_cand) begin
                    n_cand = observed;
                    n_hits = 8'd1;
                end else begin
                    n_hits = hits_step;
                end
                if (n_hits >= need) begin
                    n_shown = observed;
                    n_hits  = '0;
                end
            end else begin
                n_cand = r_shown;
                n_hits = '0;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (do_finish) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= BK_IDLE;
            r_best_valid  <= 1'b0;
            r_frame_ttc   <= TTC_INF;
            r_best_track  <= '0;
            r_best_class  <= '0;
            r_best_height <= '0;
            r_shown       <= SEV_SAFE;
            r_cand        <= SEV_SAFE;
            r_hits        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_best_valid  <= n_best_valid;
            r_frame_ttc   <= n_frame_ttc;
            r_best_track  <= n_best_track;
            r_best_class  <= n_best_class;
            r_best_height <= n_best_height;
            r_shown       <= n_shown;
            r_cand        <= n_cand;
            r_hits        <= n_hits;
            r_out_valid   <= n_out_valid;
        end
    end

    // hold the popped track while the divider runs
    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_ent_last   <= i_q_cls.last;
            r_ent_number <= i_q_number;
            r_ent_class  <= i_q_class;
            r_ent_height <= i_q_height;
        end
        if (do_finish) begin
            r_out_state  <= n_shown;
            r_out_ttc    <= r_frame_ttc;
            r_out_cvalid <= r_best_valid;
            r_out_track  <= r_best_track;
            r_out_class  <= r_best_class;
            r_out_height <= r_best_height;
        end
    end

    assign o_empty              = !r_out_valid;
    assign o_warning_state      = r_out_state;
    assign o_best_ttc_ms        = r_out_ttc;
    assign o_critical_valid     = r_out_cvalid;
    assign o_critical_track     = r_out_track;
    assign o_critical_class     = r_out_class;
    assign o_critical_height_px = r_out_height;

endmodule

>>> design/collision_warning_ttc_hysteresis_top.sv
// Top level of the time-to-collision warning block with hysteresis.
//
//  channel   ports                              transfer at rising edge when
//  -------   --------------------------------   ----------------------------
//  items     push/full, i_track_present..       push && !full
//  results   empty/pop, o_warning_state..       pop && !empty
//  config    psel/penable/pwrite/paddr/pwdata   psel && penable && pwrite
//
// A closing track in the corridor holds the back end through the pop, 20 steps of the
// serial divider and the update. A frame-end item then closes the frame in BK_FINISH,
// which waits while the previous result is unread; with no closing track it goes from
// the pop straight to BK_FINISH. Other items are dropped at the front in the cycle they arrive.
// Reset is synchronous, active low, and returns registers and frame state to defaults.
// A four-entry queue parts front and back; the back stalls only when a finished
// result still waits in the output register, and full holds the input while the queue is full.
`timescale 1ns / 1ps
module collision_warning_ttc_hysteresis_top #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_track_present,
    input  logic [15:0]           i_track_number,
    input  logic [7:0]            i_object_class,
    input  logic [COORD_BITS-1:0] i_centre_x_px,
    input  logic [COORD_BITS-1:0] i_box_height_px,
    input  logic signed [15:0]    i_height_rate,
    input  logic                  i_frame_last,
    output logic                  empty,
    input  logic                  pop,
    output logic [1:0]            o_warning_state,
    output logic [15:0]           o_best_ttc_ms,
    output logic                  o_critical_valid,
    output logic [15:0]           o_critical_track,
    output logic [7:0]            o_critical_class,
    output logic [COORD_BITS-1:0] o_critical_height_px,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);
    import cwt_pkg::*;

    localparam int QW = 2 + 16 + 8 + COORD_BITS + RATE_BITS;

    logic [COORD_BITS-1:0] r_left, r_right, r_min_h;
    logic [15:0]           r_alert, r_warn, r_caution;
    logic [7:0]            r_raise, r_clear;
    logic [2:0]            reg_idx;
    logic                  cfg_wr;
    t_cfg_back             cfg_back;

    logic                  q_push;
    logic                  q_pop;
    t_q_sts                q_sts;
    t_cls                  f_cls;
    logic [14:0]           f_rate;
    logic [QW-1:0]         q_wdata;
    logic [QW-1:0]         q_rdata;
    t_cls                  q_cls;
    logic [15:0]           q_number;
    logic [7:0]            q_class;
    logic [COORD_BITS-1:0] q_height;
    logic [14:0]           q_rate;
    t_div_req              div_req;
    t_div_sts              div_sts;

    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= '0;
            r_right   <= COORD_BITS'(RIGHT_RESET);
            r_min_h   <= '0;
            r_alert   <= 16'd1200;
            r_warn    <= 16'd2000;
            r_caution <= 16'd3000;
            r_raise   <= 8'd2;
            r_clear   <= 8'd5;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_LEFT:    r_left    <= pwdata[COORD_BITS-1:0];
                REG_RIGHT:   r_right   <= pwdata[COORD_BITS-1:0];
                REG_MIN_H:   r_min_h   <= pwdata[COORD_BITS-1:0];
                REG_ALERT:   r_alert   <= pwdata[15:0];
                REG_WARN:    r_warn    <= pwdata[15:0];
                REG_CAUTION: r_caution <= pwdata[15:0];
                REG_RAISE:   r_raise   <= pwdata[7:0];
                REG_CLEAR:   r_clear   <= pwdata[7:0];
                default:     r_left    <= r_left;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LEFT:    prdata = 32'(r_left);
            REG_RIGHT:   prdata = 32'(r_right);
            REG_MIN_H:   prdata = 32'(r_min_h);
            REG_ALERT:   prdata = 32'(r_alert);
            REG_WARN:    prdata = 32'(r_warn);
            REG_CAUTION: prdata = 32'(r_caution);
            REG_RAISE:   prdata = 32'(r_raise);
            REG_CLEAR:   prdata = 32'(r_clear);
            default:     prdata = '0;
        endcase
    end

    assign cfg_back.alert_limit   = r_alert;
    assign cfg_back.warn_limit    = r_warn;
    assign cfg_back.caution_limit = r_caution;
    assign cfg_back.raise_count   = r_raise;
    assign cfg_back.clear_count   = r_clear;

    cwt_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_push          (push),
        .i_q_sts         (q_sts),
        .i_left          (r_left),
        .i_right         (r_right),
        .i_min_height    (r_min_h),
        .i_track_present (i_track_present),
        .i_object_class  (i_object_class),
        .i_centre_x_px   (i_centre_x_px),
        .i_box_height_px (i_box_height_px),
        .i_height_rate   (i_height_rate),
        .i_frame_last    (i_frame_last),
        .o_q_push        (q_push),
        .o_cls           (f_cls),
        .o_rate          (f_rate)
    );

    assign q_wdata = {f_cls, i_track_number, i_object_class, i_box_height_px, f_rate};
    assign {q_cls, q_number, q_class, q_height, q_rate} = q_rdata;

    cwt_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_sts   (q_sts)
    );

    cwt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_sts   (div_sts)
    );

    cwt_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (cfg_back),
        .i_q_sts              (q_sts),
        .i_q_cls              (q_cls),
        .i_q_number           (q_number),
        .i_q_class            (q_class),
        .i_q_height           (q_height),
        .i_q_rate             (q_rate),
        .o_q_pop              (q_pop),
        .o_div_req            (div_req),
        .i_div_sts            (div_sts),
        .i_pop                (pop),
        .o_empty              (empty),
        .o_warning_state      (o_warning_state),
        .o_best_ttc_ms        (o_best_ttc_ms),
        .o_critical_valid     (o_critical_valid),
        .o_critical_track     (o_critical_track),
        .o_critical_class     (o_critical_class),
        .o_critical_height_px (o_critical_height_px)
    );

    assign full = q_sts.full;

`ifndef SYNTH
    // the back never drains an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_sts.empty)
        else $error("queue popped while empty");

    // a new division never starts over one in flight
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_sts.busy)
        else $error("divider restarted while busy");

    // completion only follows a running division
    a_div_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_sts.done |-> $past(div_sts.busy))
        else $error("divider done without a running division");

    // the queue never takes an item while full
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_sts.full)
        else $error("queue pushed while full");
`endif

endmodule
